@@ src/tms_pkg.sv @@
`default_nettype none

package tms_pkg;

    // operation codes carried in s_tuser
    localparam logic [2:0] OP_PORT0_WR = 3'd0;
    localparam logic [2:0] OP_PORT1_WR = 3'd1;
    localparam logic [2:0] OP_DIRECT_WR = 3'd2;
    localparam logic [2:0] OP_READ = 3'd3;
    localparam logic [2:0] OP_FILL = 3'd4;
    localparam logic [2:0] OP_SEQ_FILL = 3'd5;
    localparam logic [2:0] OP_SET_PTR = 3'd6;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_PORT0_STEP = 2'd0;
    localparam logic [1:0] REG_PORT1_STEP = 2'd1;
    localparam logic [1:0] REG_PORT0_PAGE = 2'd2;

    typedef struct packed {
        logic       port0_vert;
        logic       port1_vert;
        logic [1:0] port0_page;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       step0;
        logic       step1;
        logic [4:0] col0;
        logic [4:0] row0;
        logic [4:0] col1;
        logic [4:0] row1;
    } t_ptr_cmd;

endpackage

`default_nettype wire

@@ src/tms_ram.sv @@
`default_nettype none

module tms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_addr,
    input  wire  [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/tms_ptr.sv @@
`default_nettype none

module tms_ptr
    import tms_pkg::*;
#(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 28
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_ptr_cmd   i_cmd,
    input  t_cfg       i_cfg,
    output logic [4:0] o_p0_col,
    output logic [4:0] o_p0_row,
    output logic [4:0] o_p1_col,
    output logic [4:0] o_p1_row
);

    localparam int LAST_ROW = ((MAP_ROWS - 1) > 31) ? 31 : (MAP_ROWS - 1);

    logic [4:0] r_p0_col, r_p0_row, r_p1_col, r_p1_row;
    logic [4:0] n_p0_col, n_p0_row, n_p1_col, n_p1_row;

    // column reduced modulo the page width, at most four subtractions for 5-bit input
    function automatic logic [4:0] f_wrap(input logic [4:0] c);
        logic [6:0] t;
        t = {2'b00, c};
        for (int k = 0; k < 4; k++) begin
            if (t >= 7'(MAP_COLS)) begin
                t = t - 7'(MAP_COLS);
            end
        end
        return t[4:0];
    endfunction

    function automatic logic [4:0] f_step_col(input logic [4:0] c);
        logic [6:0] t;
        t = {2'b00, c} + 7'd1;
        if (t >= 7'(MAP_COLS)) begin
            t = '0;
        end
        return t[4:0];
    endfunction

    function automatic logic [4:0] f_step_row(input logic [4:0] r);
        return (r >= 5'(LAST_ROW)) ? 5'(LAST_ROW) : r + 5'd1;
    endfunction

    function automatic logic [4:0] f_clamp_row(input logic [4:0] r);
        return (r > 5'(LAST_ROW)) ? 5'(LAST_ROW) : r;
    endfunction

    always_comb begin
        n_p0_col = r_p0_col;
        n_p0_row = r_p0_row;
        n_p1_col = r_p1_col;
        n_p1_row = r_p1_row;
        if (i_cmd.load) begin
            n_p0_col = f_wrap(i_cmd.col0);
            n_p0_row = f_clamp_row(i_cmd.row0);
            n_p1_col = f_wrap(i_cmd.col1);
            n_p1_row = f_clamp_row(i_cmd.row1);
        end
        if (i_cmd.step0) begin
            if (i_cfg.port0_vert) begin
                n_p0_row = f_step_row(r_p0_row);
            end else begin
                n_p0_col = f_step_col(r_p0_col);
            end
        end
        if (i_cmd.step1) begin
            if (i_cfg.port1_vert) begin
                n_p1_row = f_step_row(r_p1_row);
            end else begin
                n_p1_col = f_step_col(r_p1_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_col <= '0;
            r_p0_row <= '0;
            r_p1_col <= '0;
            r_p1_row <= '0;
        end else begin
            r_p0_col <= n_p0_col;
            r_p0_row <= n_p0_row;
            r_p1_col <= n_p1_col;
            r_p1_row <= n_p1_row;
        end
    end

    assign o_p0_col = r_p0_col;
    assign o_p0_row = r_p0_row;
    assign o_p1_col = r_p1_col;
    assign o_p1_row = r_p1_row;

endmodule

`default_nettype wire

@@ src/tms_walk.sv @@
`default_nettype none

module tms_walk #(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 28,
    parameter int TILE_BITS = 16,
    parameter int SEQ_ROW_STRIDE = 64,
    parameter int SW = 3
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire                            i_seq,
    input  wire  [SW-1:0]                  i_slot,
    input  wire  [$clog2(MAP_COLS)-1:0]    i_col,
    input  wire  [$clog2(MAP_ROWS)-1:0]    i_row,
    input  wire  [$clog2(MAP_COLS)-1:0]    i_last_col,
    input  wire  [$clog2(MAP_ROWS)-1:0]    i_last_row,
    input  wire  [TILE_BITS-1:0]           i_value,
    output logic                           o_busy,
    output logic [SW-1:0]                  o_slot,
    output logic [$clog2(MAP_COLS)-1:0]    o_col,
    output logic [$clog2(MAP_ROWS)-1:0]    o_row,
    output logic [TILE_BITS-1:0]           o_value
);

    localparam int CW = $clog2(MAP_COLS);
    localparam int RW = $clog2(MAP_ROWS);

    logic                 r_busy;
    logic                 r_seq;
    logic [SW-1:0]        r_slot;
    logic [CW-1:0]        r_col, r_col0, r_last_col;
    logic [RW-1:0]        r_row, r_last_row;
    logic [TILE_BITS-1:0] r_val, r_row_val;
    logic [TILE_BITS-1:0] n_row_val;

    assign n_row_val = r_row_val + (r_seq ? TILE_BITS'(SEQ_ROW_STRIDE) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_col == r_last_col && r_row == r_last_row) begin
            r_busy <= 1'b0;
        end
    end

    // one entry written per cycle, row by row over the clipped rectangle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_seq      <= i_seq;
            r_slot     <= i_slot;
            r_col      <= i_col;
            r_col0     <= i_col;
            r_row      <= i_row;
            r_last_col <= i_last_col;
            r_last_row <= i_last_row;
            r_val      <= i_value;
            r_row_val  <= i_value;
        end else if (r_busy) begin
            if (r_col == r_last_col) begin
                r_col     <= r_col0;
                r_row     <= r_row + RW'(1);
                r_row_val <= n_row_val;
                r_val     <= n_row_val;
            end else begin
                r_col <= r_col + CW'(1);
                r_val <= r_val + (r_seq ? TILE_BITS'(1) : '0);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_slot  = r_slot;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_value = r_val;

endmodule

`default_nettype wire

@@ src/tile_map_store_with_write_ports.sv @@
// a read item gives its result on m_tdata in the cycle after it is accepted
// throughput: single accesses (port writes, direct write, read, set pointers) one item per cycle while no fill runs
// rectangle fills hold s_tready low while the entries inside the page are written
// a read also waits while an earlier read result is still held on the master side
// reset (synchronous, active low) clears port pointers, config registers and handshake state;
// the tile store is not cleared and is undefined until written
`default_nettype none

module tile_map_store_with_write_ports
    import tms_pkg::*;
#(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 28,
    parameter int BANK0_PAGES = 4,
    parameter int TILE_BITS = 16,
    parameter int SEQ_ROW_STRIDE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // page[2:0] col[7:3] row[12:8] span_cols[18:13] span_rows[23:19]
    // tile_value[39:24] col_b[44:40] row_b[49:45], zero fill above
    input  wire  [55:0] s_tdata,
    // operation[2:0]
    input  wire  [2:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // read_value[15:0]
    output logic [15:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAGE_SIZE = MAP_COLS * MAP_ROWS;
    localparam int DEPTH = (BANK0_PAGES + 2) * PAGE_SIZE;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(BANK0_PAGES + 2);
    localparam int CW = $clog2(MAP_COLS);
    localparam int RW = $clog2(MAP_ROWS);

    // input fields
    logic [2:0]  in_op;
    logic [2:0]  in_page;
    logic [4:0]  in_col, in_row, in_col_b, in_row_b;
    logic [5:0]  in_span_cols;
    logic [4:0]  in_span_rows;
    logic [15:0] in_value;

    assign in_op        = s_tuser;
    assign in_page      = s_tdata[2:0];
    assign in_col       = s_tdata[7:3];
    assign in_row       = s_tdata[12:8];
    assign in_span_cols = s_tdata[18:13];
    assign in_span_rows = s_tdata[23:19];
    assign in_value     = s_tdata[39:24];
    assign in_col_b     = s_tdata[44:40];
    assign in_row_b     = s_tdata[49:45];

    // configuration registers
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PORT0_STEP: r_cfg.port0_vert <= pwdata[0];
                REG_PORT1_STEP: r_cfg.port1_vert <= pwdata[0];
                REG_PORT0_PAGE: r_cfg.port0_page <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PORT0_STEP: prdata = {31'd0, r_cfg.port0_vert};
            REG_PORT1_STEP: prdata = {31'd0, r_cfg.port1_vert};
            REG_PORT0_PAGE: prdata = {30'd0, r_cfg.port0_page};
            default:        prdata = '0;
        endcase
    end

    // handshake
    logic walk_busy;
    logic r_out_valid;
    logic r_out_zero;
    logic in_acc;
    logic out_free;

    assign out_free = !r_out_valid || m_tready;
    assign s_tready = !walk_busy && (out_free || in_op != OP_READ);
    assign in_acc   = s_tvalid && s_tready;

    // port pointers
    t_ptr_cmd   ptr_cmd;
    logic [4:0] p0_col, p0_row, p1_col, p1_row;

    assign ptr_cmd.load  = in_acc && in_op == OP_SET_PTR;
    assign ptr_cmd.step0 = in_acc && in_op == OP_PORT0_WR;
    assign ptr_cmd.step1 = in_acc && in_op == OP_PORT1_WR;
    assign ptr_cmd.col0  = in_col;
    assign ptr_cmd.row0  = in_row;
    assign ptr_cmd.col1  = in_col_b;
    assign ptr_cmd.row1  = in_row_b;

    tms_ptr #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ptr_cmd),
        .i_cfg    (r_cfg),
        .o_p0_col (p0_col),
        .o_p0_row (p0_row),
        .o_p1_col (p1_col),
        .o_p1_row (p1_row)
    );

    // page slot of the addressed page and of port 0
    logic [SW-1:0] in_slot, p0_slot;

    always_comb begin
        if ({1'b0, in_page} < 4'(BANK0_PAGES)) begin
            in_slot = SW'(in_page);
        end else if ({1'b0, in_page} == 4'(BANK0_PAGES)) begin
            in_slot = SW'(BANK0_PAGES);
        end else begin
            in_slot = SW'(BANK0_PAGES + 1);
        end
        if ({2'b00, r_cfg.port0_page} >= 4'(BANK0_PAGES)) begin
            p0_slot = SW'(BANK0_PAGES - 1);
        end else begin
            p0_slot = SW'(r_cfg.port0_page);
        end
    end

    // single access target
    logic [SW-1:0] acc_slot;
    logic [4:0]    acc_col, acc_row;
    logic          acc_on_page;

    always_comb begin
        unique case (in_op)
            OP_PORT0_WR: begin
                acc_slot = p0_slot;
                acc_col  = p0_col;
                acc_row  = p0_row;
            end
            OP_PORT1_WR: begin
                acc_slot = SW'(BANK0_PAGES);
                acc_col  = p1_col;
                acc_row  = p1_row;
            end
            default: begin
                acc_slot = in_slot;
                acc_col  = in_col;
                acc_row  = in_row;
            end
        endcase
    end

    assign acc_on_page = ({3'b000, acc_col} < 8'(MAP_COLS)) && ({3'b000, acc_row} < 8'(MAP_ROWS));

    // rectangle clipping at the right and bottom page edges
    logic [7:0] room_c, room_r, n_cols, n_rows, last_c, last_r;
    logic       org_on_page;
    logic       fill_go;

    assign room_c = 8'(MAP_COLS) - {3'b000, in_col};
    assign room_r = 8'(MAP_ROWS) - {3'b000, in_row};
    assign n_cols = ({2'b00, in_span_cols} < room_c) ? {2'b00, in_span_cols} : room_c;
    assign n_rows = ({3'b000, in_span_rows} < room_r) ? {3'b000, in_span_rows} : room_r;
    assign last_c = {3'b000, in_col} + n_cols - 8'd1;
    assign last_r = {3'b000, in_row} + n_rows - 8'd1;
    assign org_on_page = ({3'b000, in_col} < 8'(MAP_COLS)) && ({3'b000, in_row} < 8'(MAP_ROWS));
    assign fill_go = in_acc && (in_op == OP_FILL || in_op == OP_SEQ_FILL) && org_on_page
                     && in_span_cols != 6'd0 && in_span_rows != 5'd0;

    logic [SW-1:0]        w_slot;
    logic [CW-1:0]        w_col;
    logic [RW-1:0]        w_row;
    logic [TILE_BITS-1:0] w_value;

    tms_walk #(
        .MAP_COLS       (MAP_COLS),
        .MAP_ROWS       (MAP_ROWS),
        .TILE_BITS      (TILE_BITS),
        .SEQ_ROW_STRIDE (SEQ_ROW_STRIDE),
        .SW             (SW)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fill_go),
        .i_seq      (in_op == OP_SEQ_FILL),
        .i_slot     (in_slot),
        .i_col      (CW'(in_col)),
        .i_row      (RW'(in_row)),
        .i_last_col (CW'(last_c)),
        .i_last_row (RW'(last_r)),
        .i_value    (TILE_BITS'(in_value)),
        .o_busy     (walk_busy),
        .o_slot     (w_slot),
        .o_col      (w_col),
        .o_row      (w_row),
        .o_value    (w_value)
    );

    // memory port
    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] slot,
                                             input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
        return AW'(32'(slot) * 32'(PAGE_SIZE) + 32'(row) * 32'(MAP_COLS) + 32'(col));
    endfunction

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_addr;
    logic [TILE_BITS-1:0] ram_wdata, ram_rdata;
    logic                 single_wr;

    assign single_wr = in_acc && acc_on_page
                       && (in_op == OP_PORT0_WR || in_op == OP_PORT1_WR || in_op == OP_DIRECT_WR);
    assign ram_we    = walk_busy || single_wr;
    assign ram_re    = in_acc && in_op == OP_READ && acc_on_page;
    assign ram_addr  = walk_busy ? f_addr(w_slot, w_row, w_col)
                                 : f_addr(acc_slot, RW'(acc_row), CW'(acc_col));
    assign ram_wdata = walk_busy ? w_value : TILE_BITS'(in_value);

    tms_ram #(
        .WIDTH (TILE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // result stage: ram read data holds until the next read inside the page is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && in_op == OP_READ) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_op == OP_READ) begin
            r_out_zero <= !acc_on_page;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_zero ? 16'd0 : 16'(ram_rdata);

    localparam int LAST_ROW = ((MAP_ROWS - 1) > 31) ? 31 : (MAP_ROWS - 1);

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_READ) |=> m_tvalid)
        else $error("read item without a result");

    a_fill_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_busy |-> !ram_re)
        else $error("memory read during rectangle fill");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_addr) < 32'(DEPTH)))
        else $error("memory write outside the store");

    a_ptr_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p0_row <= 5'(LAST_ROW)) && (p1_row <= 5'(LAST_ROW)))
        else $error("port pointer row past the last row");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tms_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PAGE_ENTRIES = 32 * 28;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  page;
        logic [4:0]  col;
        logic [4:0]  row;
        logic [5:0]  span_cols;
        logic [4:0]  span_rows;
        logic [15:0] tile_value;
        logic [4:0]  col_b;
        logic [4:0]  row_b;
    } t_tile_item;

    // shadow copy of the tile pages, port pointers and config registers
    class tile_map_mirror;
        localparam int MAP_COLS = 32;
        localparam int MAP_ROWS = 28;
        localparam int LAST_ROW = 27;
        localparam int SEQ_STRIDE = 64;

        logic [15:0] tiles [0:6*32*28-1];
        logic [4:0]  p0_col, p0_row, p1_col, p1_row;
        t_cfg        cfg;
        logic [15:0] pending_reads [$];
        int unsigned mismatches;
        int          last_slot, last_col, last_row;

        function new();
            p0_col = 0; p0_row = 0; p1_col = 0; p1_row = 0;
            cfg = '0;
            mismatches = 0;
            last_slot = 0; last_col = 0; last_row = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_PORT0_STEP: cfg.port0_vert = val[0];
                REG_PORT1_STEP: cfg.port1_vert = val[0];
                REG_PORT0_PAGE: cfg.port0_page = val[1:0];
                default: ;
            endcase
        endfunction

        function int page_slot(logic [2:0] page);
            if (page < 3'd4) return int'(page);
            if (page == 3'd4) return 4;
            return 5;
        endfunction

        function logic [4:0] next_row(logic [4:0] r);
            return (r >= 5'(LAST_ROW)) ? 5'(LAST_ROW) : r + 5'd1;
        endfunction

        function logic [4:0] clamp_row(logic [4:0] r);
            return (r > 5'(LAST_ROW)) ? 5'(LAST_ROW) : r;
        endfunction

        // entries past the page edge are dropped
        function void put(int slot, int c, int r, logic [15:0] v);
            if (c < MAP_COLS && r < MAP_ROWS) begin
                tiles[slot * PAGE_ENTRIES + r * MAP_COLS + c] = v;
                last_slot = slot;
                last_col = c;
                last_row = r;
            end
        endfunction

        function void apply_item(t_tile_item it);
            int slot;
            logic [15:0] w;
            slot = page_slot(it.page);
            case (it.op)
                OP_PORT0_WR: begin
                    put(int'(cfg.port0_page), int'(p0_col), int'(p0_row), it.tile_value);
                    // 5-bit column wraps past the last column
                    if (cfg.port0_vert) p0_row = next_row(p0_row);
                    else p0_col = p0_col + 5'd1;
                end
                OP_PORT1_WR: begin
                    // port 1 always lands in the second table
                    put(4, int'(p1_col), int'(p1_row), it.tile_value);
                    if (cfg.port1_vert) p1_row = next_row(p1_row);
                    else p1_col = p1_col + 5'd1;
                end
                OP_DIRECT_WR: put(slot, int'(it.col), int'(it.row), it.tile_value);
                OP_READ: begin
                    if (int'(it.row) < MAP_ROWS)
                        pending_reads.push_back(
                            tiles[slot * PAGE_ENTRIES + int'(it.row) * MAP_COLS + int'(it.col)]);
                    else
                        pending_reads.push_back(16'd0);
                end
                OP_FILL, OP_SEQ_FILL: begin
                    for (int ly = 0; ly < int'(it.span_rows); ly++) begin
                        for (int lx = 0; lx < int'(it.span_cols); lx++) begin
                            w = it.tile_value;
                            if (it.op == OP_SEQ_FILL)
                                w = it.tile_value + 16'(ly * SEQ_STRIDE + lx);
                            put(slot, int'(it.col) + lx, int'(it.row) + ly, w);
                        end
                    end
                end
                OP_SET_PTR: begin
                    p0_col = it.col;
                    p0_row = clamp_row(it.row);
                    p1_col = it.col_b;
                    p1_row = clamp_row(it.row_b);
                end
                default: ;
            endcase
        endfunction

        task check_read(logic [15:0] got);
            logic [15:0] want;
            if (pending_reads.size() == 0) begin
                report($sformatf("read value %h with no read pending", got));
                return;
            end
            want = pending_reads.pop_front();
            if (got !== want)
                report($sformatf("read_value got %h expected %h", got, want));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    wire         s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    wire         m_tvalid;
    logic        m_tready;
    wire  [15:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    tile_map_mirror mirror;
    int          cycle_count;
    bit          src_gaps_on;
    bit          sink_gaps_on;
    int          stall_request;

    tile_map_store_with_write_ports u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            mirror.check_read(m_tdata);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            if (stall_request > 0) begin
                m_tready <= 1'b0;
                repeat (stall_request) @(posedge i_clk);
                stall_request = 0;
            end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic t_tile_item make_item(logic [2:0] op, logic [2:0] page,
                                             logic [4:0] col, logic [4:0] row,
                                             logic [5:0] sc, logic [4:0] sr,
                                             logic [15:0] val, logic [4:0] cb,
                                             logic [4:0] rb);
        t_tile_item it;
        it.op = op; it.page = page; it.col = col; it.row = row;
        it.span_cols = sc; it.span_rows = sr; it.tile_value = val;
        it.col_b = cb; it.row_b = rb;
        return it;
    endfunction

    function automatic t_tile_item random_item();
        t_tile_item it;
        int pick;
        it.page = 3'($urandom_range(0, 7));
        it.col = 5'($urandom_range(0, 31));
        it.row = 5'($urandom_range(0, 31));
        it.tile_value = 16'($urandom);
        it.col_b = 5'($urandom_range(0, 31));
        it.row_b = 5'($urandom_range(0, 31));
        // mostly small rectangles, a few up to the full field range
        if ($urandom_range(0, 9) == 0) begin
            it.span_cols = 6'($urandom_range(0, 63));
            it.span_rows = 5'($urandom_range(0, 31));
        end else begin
            it.span_cols = 6'($urandom_range(0, 8));
            it.span_rows = 5'($urandom_range(0, 6));
        end
        pick = $urandom_range(0, 99);
        if (pick < 15) it.op = OP_PORT0_WR;
        else if (pick < 30) it.op = OP_PORT1_WR;
        else if (pick < 45) it.op = OP_DIRECT_WR;
        else if (pick < 72) it.op = OP_READ;
        else if (pick < 81) it.op = OP_FILL;
        else if (pick < 90) it.op = OP_SEQ_FILL;
        else if (pick < 98) it.op = OP_SET_PTR;
        else it.op = 3'd7;
        // half the reads look at the entry written last
        if (it.op == OP_READ && $urandom_range(0, 1) == 1) begin
            it.page = (mirror.last_slot == 5) ? 3'($urandom_range(5, 7))
                                              : 3'(mirror.last_slot);
            it.col = 5'(mirror.last_col);
            it.row = 5'(mirror.last_row);
        end
        return it;
    endfunction

    // leaves tvalid high on return so the next item can follow directly
    task automatic send_item(t_tile_item it);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {6'd0, it.row_b, it.col_b, it.tile_value, it.span_rows,
                    it.span_cols, it.row, it.col, it.page};
        do @(posedge i_clk); while (!s_tready);
        mirror.apply_item(it);
    endtask

    // a fill may still be writing after the last read result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (mirror.pending_reads.size() != 0) @(posedge i_clk);
        repeat (PAGE_ENTRIES + 8) @(posedge i_clk);
    endtask

    task automatic write_config(logic port0_vert, logic port1_vert, logic [1:0] port0_page);
        logic [31:0] vals [3];
        logic [1:0]  idxs [3];
        logic [31:0] mask;
        idxs[0] = REG_PORT0_STEP; vals[0] = {31'd0, port0_vert};
        idxs[1] = REG_PORT1_STEP; vals[1] = {31'd0, port1_vert};
        idxs[2] = REG_PORT0_PAGE; vals[2] = {30'd0, port0_page};
        psel <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            mask = (idxs[k] == REG_PORT0_PAGE) ? 32'd3 : 32'd1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idxs[k], 2'b00};
            pwdata <= vals[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            mirror.set_reg(idxs[k], vals[k]);
            // read back the same register
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if ((prdata & mask) !== vals[k])
                mirror.report($sformatf("register %0d read %h expected %h",
                                        idxs[k], prdata, vals[k]));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        // every page written once so that later reads never hit an unwritten entry
        send_item(make_item(OP_SEQ_FILL, 3'd0, 5'd0, 5'd0, 6'd32, 5'd28, 16'h0000, 5'd0, 5'd0));
        send_item(make_item(OP_SEQ_FILL, 3'd1, 5'd0, 5'd0, 6'd32, 5'd28, 16'hffc0, 5'd0, 5'd0));
        send_item(make_item(OP_FILL, 3'd2, 5'd0, 5'd0, 6'd63, 5'd31, 16'ha5a5, 5'd0, 5'd0));
        send_item(make_item(OP_SEQ_FILL, 3'd3, 5'd0, 5'd0, 6'd32, 5'd28, 16'h1234, 5'd0, 5'd0));
        send_item(make_item(OP_SEQ_FILL, 3'd4, 5'd0, 5'd0, 6'd32, 5'd28, 16'h8000, 5'd0, 5'd0));
        send_item(make_item(OP_FILL, 3'd7, 5'd0, 5'd0, 6'd32, 5'd28, 16'h5a5a, 5'd0, 5'd0));
        // third table seen through another page number
        send_item(make_item(OP_READ, 3'd6, 5'd31, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        // sequence value wraps at 16 bits
        send_item(make_item(OP_READ, 3'd1, 5'd31, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        // row past the page reads as zero
        send_item(make_item(OP_READ, 3'd0, 5'd31, 5'd31, 6'd63, 5'd31, 16'hffff, 5'd31, 5'd31));
        // empty rectangles
        send_item(make_item(OP_FILL, 3'd0, 5'd3, 5'd3, 6'd0, 5'd5, 16'hdead, 5'd0, 5'd0));
        send_item(make_item(OP_SEQ_FILL, 3'd0, 5'd3, 5'd3, 6'd5, 5'd0, 16'hbeef, 5'd0, 5'd0));
        // rectangle clipped at the lower right corner
        send_item(make_item(OP_FILL, 3'd0, 5'd30, 5'd26, 6'd4, 5'd4, 16'hffff, 5'd0, 5'd0));
        send_item(make_item(OP_READ, 3'd0, 5'd31, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        // pointer rows past the page saturate
        send_item(make_item(OP_SET_PTR, 3'd0, 5'd31, 5'd31, 6'd0, 5'd0, 16'd0, 5'd31, 5'd29));
        send_item(make_item(OP_PORT0_WR, 3'd5, 5'd0, 5'd0, 6'd0, 5'd0, 16'hffff, 5'd0, 5'd0));
        send_item(make_item(OP_PORT1_WR, 3'd0, 5'd0, 5'd0, 6'd0, 5'd0, 16'h0001, 5'd0, 5'd0));
        // column pointers have wrapped to zero
        send_item(make_item(OP_PORT0_WR, 3'd0, 5'd0, 5'd0, 6'd0, 5'd0, 16'h7777, 5'd0, 5'd0));
        send_item(make_item(OP_READ, 3'd0, 5'd31, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        send_item(make_item(OP_READ, 3'd0, 5'd0, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        send_item(make_item(OP_READ, 3'd4, 5'd31, 5'd27, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        // direct write off the page is ignored
        send_item(make_item(OP_DIRECT_WR, 3'd5, 5'd0, 5'd0, 6'd0, 5'd0, 16'h0000, 5'd0, 5'd0));
        send_item(make_item(OP_DIRECT_WR, 3'd5, 5'd0, 5'd30, 6'd0, 5'd0, 16'h4321, 5'd0, 5'd0));
        send_item(make_item(OP_READ, 3'd5, 5'd0, 5'd0, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
        // unused operation with every field at its top
        send_item(make_item(3'd7, 3'd7, 5'd31, 5'd31, 6'd63, 5'd31, 16'hffff, 5'd31, 5'd31));
        send_item(make_item(OP_READ, 3'd3, 5'd0, 5'd0, 6'd0, 5'd0, 16'd0, 5'd0, 5'd0));
    endtask

    initial begin
        mirror = new();
        cycle_count = 0;
        stall_request = 0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: write_config(1'b1, 1'b1, 2'd3);
                1: write_config(1'b0, 1'b1, 2'd1);
                2: write_config(1'b1, 1'b0, 2'd2);
                3: write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                2'($urandom_range(0, 3)));
                default: write_config(1'b0, 1'b0, 2'd0);
            endcase
            if (phase == 4) begin
                src_gaps_on = 1'b0;
                sink_gaps_on = 1'b0;
            end
            if (phase == 1) begin
                // long receiver hold-off while reads keep coming
                src_gaps_on = 1'b0;
                stall_request = 400;
                for (int k = 0; k < 40; k++) begin
                    t_tile_item rd;
                    rd = random_item();
                    rd.op = OP_READ;
                    send_item(rd);
                end
                src_gaps_on = 1'b1;
            end
            for (int k = 0; k < 160; k++)
                send_item(random_item());
        end

        s_tvalid <= 1'b0;
        for (int k = 0; k < 4000 && mirror.pending_reads.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mirror.pending_reads.size() != 0)
            mirror.report($sformatf("%0d read results never arrived",
                                    mirror.pending_reads.size()));
        if (mirror.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tms_pkg.sv
src/tms_ram.sv
src/tms_ptr.sv
src/tms_walk.sv
src/tile_map_store_with_write_ports.sv
tb/sv/tb_top.sv
